// File: src/bpa_pkg.sv
// bpa_pkg: shared types and constants for the bitmap page allocator
// used by bitmap_page_allocator; no dependencies
`default_nettype none

package bpa_pkg;

  // default capacity and page size
  localparam int unsigned MAX_PAGES_DEF  = 65536;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  // map word geometry
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WBIT_W    = 5;

  // byte fields and counters
  localparam int unsigned ADDR_IN_W  = 40;
  localparam int unsigned ADDR_OUT_W = 28;
  localparam int unsigned COUNT_W    = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP,
    ST_CLAMP,
    ST_READ,
    ST_MODIFY,
    ST_COUNT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: src/bitmap_page_allocator.sv
// Bitmap page allocator: one used bit per page kept in 32-bit ram words, plus a free count.
// Each operation passes through prep and clamp; one that touches no page then goes to done,
// else each map word visited is read, updated and counted in turn. One word in flight at a time.
// Reset: async active low; then an init pass over every map word sets every
// page used, during which no input word is taken (config writes are still taken).
// Depends on bpa_pkg and bpa_ram.
`default_nettype none

module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bpa_pkg::COUNT_W-1:0]      cfg_total_pages_i,
  // input words
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [bpa_pkg::ADDR_IN_W-1:0]    base_address_i,
  input  wire logic [bpa_pkg::ADDR_IN_W-1:0]    region_length_i,
  // result words
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [bpa_pkg::ADDR_OUT_W-1:0]   page_address_o,
  output logic      [bpa_pkg::COUNT_W-1:0]      free_pages_o,
  output logic      [bpa_pkg::COUNT_W-1:0]      used_pages_o
);

  localparam int unsigned WB    = bpa_pkg::WORD_BITS;
  localparam int unsigned CNT_W = bpa_pkg::COUNT_W;
  localparam int unsigned PW    = $clog2(MAX_PAGES);
  localparam int unsigned CW    = $clog2(MAX_PAGES + 1);
  localparam int unsigned WORDS = (MAX_PAGES + WB - 1) / WB;
  localparam int unsigned WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned RAW_W = 42 - PAGE_SHIFT;
  localparam int unsigned CMP_W = (RAW_W > CW) ? RAW_W : CW;
  localparam int unsigned TW    = (CW > CNT_W) ? CW : CNT_W;
  localparam logic [41:0] PMASK = (42'd1 << PAGE_SHIFT) - 42'd1;

  bpa_pkg::state_e state_q, state_d;

  // control registers
  logic [CNT_W-1:0] total_cfg_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [WIW-1:0]   w_q, w_d;
  logic             out_valid_q;

  // payload registers
  bpa_pkg::op_e                  op_q;
  logic [bpa_pkg::ADDR_IN_W-1:0] base_q, len_q;
  logic [CMP_W-1:0]              s_q, e_q;
  logic                          skip_q;
  logic [PW-1:0]                 start_q, last_q;
  logic [WIW-1:0]                ew_q;
  logic [5:0]                    n_q;
  logic                          found_q;
  logic [bpa_pkg::ADDR_OUT_W-1:0] addr_q;
  logic [bpa_pkg::ADDR_OUT_W-1:0] page_address_q;
  logic [CNT_W-1:0]              free_q, used_q;

  // ram ports
  logic           ram_we, ram_re;
  logic [WIW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0]  ram_wdata, ram_rdata;

  // handshake events
  logic in_fire, out_load, last_word, empty;

  // effective page total
  logic [TW-1:0] tp_ext;
  logic [CW-1:0] total_eff;

  always_comb begin
    tp_ext    = TW'(total_cfg_q);
    total_eff = (tp_ext > TW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(tp_ext);
  end

  // region bounds before clamping
  logic [41:0]      base_x, len_x, sum_x;
  logic [CMP_W-1:0] s_raw, e_raw;
  logic             skip_raw;

  always_comb begin
    base_x   = 42'(base_q);
    len_x    = 42'(len_q);
    sum_x    = base_x + len_x;
    s_raw    = CMP_W'(base_x >> PAGE_SHIFT);
    e_raw    = s_raw + CMP_W'(1);
    skip_raw = 1'b0;
    case (op_q)
      bpa_pkg::OP_ALLOC: begin
        s_raw    = CMP_W'(1);
        e_raw    = CMP_W'(total_eff);
        skip_raw = (count_q == '0);
      end
      bpa_pkg::OP_FREE: begin
        skip_raw = (base_q == '0);
      end
      bpa_pkg::OP_RELEASE: begin
        s_raw = CMP_W'((base_x + PMASK) >> PAGE_SHIFT);
        e_raw = CMP_W'(sum_x >> PAGE_SHIFT);
      end
      default: begin
        e_raw = CMP_W'((sum_x + PMASK) >> PAGE_SHIFT);
      end
    endcase
  end

  // clamp to the page total, release never touches page zero
  logic [CMP_W-1:0] s_c, e_c, e_m1;
  logic [31:0]      s_c_x, last_c_x;

  always_comb begin
    e_c = (e_q > CMP_W'(total_eff)) ? CMP_W'(total_eff) : e_q;
    s_c = (op_q == bpa_pkg::OP_RELEASE && s_q == '0) ? CMP_W'(1) : s_q;
    empty    = skip_q || (s_c >= e_c);
    e_m1     = e_c - CMP_W'(1);
    s_c_x    = 32'(PW'(s_c));
    last_c_x = 32'(PW'(e_m1));
  end

  // word update: range mask, first-fit search, changed bits
  logic [31:0]              start_x, last_x;
  logic [WIW-1:0]           sw;
  logic [WB-1:0]            lo_mask, hi_mask, mask, avail, changed, new_word;
  logic [bpa_pkg::WBIT_W-1:0] hit_idx;
  logic                     hit;
  logic [5:0]               pop;
  logic [63:0]              hit_addr;

  always_comb begin
    start_x = 32'(start_q);
    last_x  = 32'(last_q);
    sw      = WIW'(start_x >> bpa_pkg::WBIT_W);
    lo_mask = (w_q == sw) ? ({WB{1'b1}} << start_x[bpa_pkg::WBIT_W-1:0]) : {WB{1'b1}};
    hi_mask = (w_q == ew_q) ? ({WB{1'b1}} >> (~last_x[bpa_pkg::WBIT_W-1:0])) : {WB{1'b1}};
    mask    = lo_mask & hi_mask;
    avail   = ~ram_rdata & mask;
    hit     = 1'b0;
    hit_idx = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit     = 1'b1;
        hit_idx = bpa_pkg::WBIT_W'(b);
      end
    end
    case (op_q)
      bpa_pkg::OP_ALLOC: begin
        changed  = hit ? (WB'(1) << hit_idx) : '0;
        new_word = ram_rdata | changed;
      end
      bpa_pkg::OP_RESERVE: begin
        changed  = avail;
        new_word = ram_rdata | mask;
      end
      default: begin
        changed  = ram_rdata & mask;
        new_word = ram_rdata & ~mask;
      end
    endcase
    pop = '0;
    for (int b = 0; b < WB; b++) begin
      pop = pop + 6'(changed[b]);
    end
    hit_addr = 64'({w_q, hit_idx}) << PAGE_SHIFT;
  end

  // saturating free count update
  logic [CNT_W:0] count_up;

  always_comb begin
    count_up = {1'b0, count_q} + (CNT_W + 1)'(n_q);
    count_d  = count_q;
    if (state_q == bpa_pkg::ST_COUNT) begin
      if (op_q == bpa_pkg::OP_ALLOC || op_q == bpa_pkg::OP_RESERVE) begin
        count_d = (CNT_W'(n_q) > count_q) ? '0 : count_q - CNT_W'(n_q);
      end else begin
        count_d = count_up[CNT_W] ? bpa_pkg::COUNT_MAX : count_up[CNT_W-1:0];
      end
    end
  end

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_load  = (state_q == bpa_pkg::ST_DONE) && (!out_valid_q || out_ready_i);
  assign last_word = found_q || (w_q == ew_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpa_pkg::ST_INIT:   if (w_q == WIW'(WORDS - 1)) state_d = bpa_pkg::ST_IDLE;
      bpa_pkg::ST_IDLE:   if (in_fire) state_d = bpa_pkg::ST_PREP;
      bpa_pkg::ST_PREP:   state_d = bpa_pkg::ST_CLAMP;
      bpa_pkg::ST_CLAMP:  state_d = empty ? bpa_pkg::ST_DONE : bpa_pkg::ST_READ;
      bpa_pkg::ST_READ:   state_d = bpa_pkg::ST_MODIFY;
      bpa_pkg::ST_MODIFY: state_d = bpa_pkg::ST_COUNT;
      bpa_pkg::ST_COUNT:  state_d = last_word ? bpa_pkg::ST_DONE : bpa_pkg::ST_MODIFY;
      bpa_pkg::ST_DONE:   if (out_load) state_d = bpa_pkg::ST_IDLE;
      default:            state_d = bpa_pkg::ST_INIT;
    endcase
  end

  // sequencer outputs: handshakes, ram control, word pointer
  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = w_q;
    ram_wdata   = new_word;
    ram_re      = 1'b0;
    ram_raddr   = w_q;
    w_d         = w_q;
    unique case (state_q)
      bpa_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {WB{1'b1}};
        w_d       = (w_q == WIW'(WORDS - 1)) ? '0 : w_q + WIW'(1);
      end
      bpa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      bpa_pkg::ST_CLAMP: begin
        w_d = WIW'(s_c_x >> bpa_pkg::WBIT_W);
      end
      bpa_pkg::ST_READ: begin
        ram_re = 1'b1;
      end
      bpa_pkg::ST_MODIFY: begin
        ram_we = 1'b1;
      end
      bpa_pkg::ST_COUNT: begin
        if (!last_word) begin
          w_d       = w_q + WIW'(1);
          ram_re    = 1'b1;
          ram_raddr = w_q + WIW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpa_pkg::ST_INIT;
      total_cfg_q <= '0;
      count_q     <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      w_q     <= w_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_cfg_q <= cfg_total_pages_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= bpa_pkg::op_e'(operation_i);
      base_q  <= base_address_i;
      len_q   <= region_length_i;
      found_q <= 1'b0;
      addr_q  <= '0;
    end
    if (state_q == bpa_pkg::ST_PREP) begin
      s_q    <= s_raw;
      e_q    <= e_raw;
      skip_q <= skip_raw;
    end
    if (state_q == bpa_pkg::ST_CLAMP) begin
      start_q <= PW'(s_c);
      last_q  <= PW'(e_m1);
      ew_q    <= WIW'(last_c_x >> bpa_pkg::WBIT_W);
    end
    if (state_q == bpa_pkg::ST_MODIFY) begin
      n_q <= pop;
      if (op_q == bpa_pkg::OP_ALLOC && hit) begin
        found_q <= 1'b1;
        addr_q  <= hit_addr[bpa_pkg::ADDR_OUT_W-1:0];
      end
    end
    if (out_load) begin
      page_address_q <= addr_q;
      free_q         <= count_q;
      used_q         <= (TW'(total_eff) >= TW'(count_q))
                        ? CNT_W'(TW'(total_eff) - TW'(count_q)) : '0;
    end
  end

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign page_address_o = page_address_q;
  assign free_pages_o   = free_q;
  assign used_pages_o   = used_q;

  // no new word is taken while one is in progress
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input taken while busy");

  // the free count moves only in the count step
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == bpa_pkg::ST_COUNT))
    else $error("free count changed outside count step");

  // the map is never written while idle or waiting on the result side
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == bpa_pkg::ST_INIT || state_q == bpa_pkg::ST_MODIFY))
    else $error("map written outside init or modify");

  // a result is loaded only when the result register is free or drained
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && state_q == bpa_pkg::ST_DONE) |=> $stable(free_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: src/bpa_ram.sv
// bpa_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
